### hw/rtl/pffl_pkg.sv
// Shared types and constants for the page frame free-list allocator.
// No dependencies; imported by page_frame_free_list_allocator.
`default_nettype none

package pffl_pkg;

  localparam int FRAMES_DEF      = 256;
  localparam int MAX_REQUEST_DEF = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [4:0] count;
    logic [7:0] free_frame;
  } req_t;

  typedef struct packed {
    logic [7:0] granted_frame;
    logic       status;
    logic       last;
  } resp_t;

endpackage

`default_nettype wire

### hw/rtl/page_frame_free_list_allocator.sv
// Page frame allocator: LIFO free list in a next-pointer memory.
// Depends on pffl_pkg (request/response structs, command and status codes).
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one command transaction at a time:
//   allocate count frames, or free one frame. resp channel (resp_valid/resp_ready/resp)
//   returns results: one per granted frame with last set on the final one, or a
//   single result for a free or a refused command.
//   Sequencing: each granted frame takes a next-pointer memory read (ST_RD), then
//   a head update and result load (ST_POP), one frame after another; free and
//   refused commands load their single result from ST_DONE or ST_REFUSE. The single
//   read port of the next-pointer memory serialises the frames. req_ready is high
//   only when the sequencer is idle.
//   Reset: after rst the block walks the next-pointer memory, one entry per cycle,
//   chaining every frame in ascending order; during this sweep req_ready stays low.
//   head is then frame 0 and all frames are free.
//   Stalls: resp is a single output register; while it holds an untaken
//   transaction the sequencer waits before loading the next result.
`default_nettype none

module page_frame_free_list_allocator #(
  parameter int FRAMES      = pffl_pkg::FRAMES_DEF,
  parameter int MAX_REQUEST = pffl_pkg::MAX_REQUEST_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire pffl_pkg::req_t  req,
  output logic                 resp_valid,
  input  wire logic            resp_ready,
  output pffl_pkg::resp_t      resp
);
  import pffl_pkg::*;

  localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;   // memory index
  localparam int PW = $clog2(FRAMES + 1);                  // pointer incl. end mark
  localparam int EW = (PW > 8) ? PW : 8;                   // frame compare width
  localparam int CW = (PW > 7) ? PW : 7;                   // count compare width
  localparam int RW = $clog2(MAX_REQUEST + 1);             // remaining counter

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_POP    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;
  localparam logic [2:0] ST_REFUSE = 3'd5;

  logic [PW-1:0] next_mem [FRAMES];

  logic [2:0]    state;
  logic [AW-1:0] init_idx;
  logic [PW-1:0] head;
  logic [PW-1:0] free_count;
  logic [RW-1:0] remaining;
  logic [PW-1:0] rd_data;

  logic          req_fire;
  logic          slot_free;
  logic          resp_load;
  logic [EW-1:0] frame_ext;
  logic [CW-1:0] count_ext;
  logic          alloc_bad;
  logic          free_bad;
  logic          head_valid;

  assign req_ready  = (state == ST_IDLE);
  assign req_fire   = req_valid && req_ready;
  assign slot_free  = !resp_valid || resp_ready;
  assign resp_load  = slot_free &&
                      (state == ST_POP || state == ST_DONE || state == ST_REFUSE);
  assign frame_ext  = EW'(req.free_frame);
  assign count_ext  = CW'(req.count);
  assign head_valid = (head < PW'(FRAMES));

  assign alloc_bad = (req.count == 5'd0) || (count_ext > CW'(MAX_REQUEST)) ||
                     (count_ext > CW'(free_count));
  assign free_bad  = (free_count == PW'(FRAMES)) || (frame_ext >= EW'(FRAMES));

  // next-pointer memory: init sweep and pushes write, pops read
  always_ff @(posedge clk) begin
    if (state == ST_INIT) begin
      next_mem[init_idx] <= PW'(init_idx) + PW'(1);
    end else if (req_fire && req.cmd == CMD_FREE && !free_bad) begin
      next_mem[frame_ext[AW-1:0]] <= head;
    end
    if (state == ST_RD && head_valid) begin
      rd_data <= next_mem[head[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      init_idx   <= '0;
      head       <= '0;
      free_count <= PW'(FRAMES);
      remaining  <= '0;
      resp_valid <= 1'b0;
    end else begin
      if (resp_valid && resp_ready && !resp_load) begin
        resp_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          init_idx <= init_idx + AW'(1);
          if (init_idx == AW'(FRAMES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            if (req.cmd == CMD_ALLOC) begin
              if (alloc_bad) begin
                state <= ST_REFUSE;
              end else begin
                remaining <= RW'(req.count);
                state     <= ST_RD;
              end
            end else if (free_bad) begin
              state <= ST_REFUSE;
            end else begin
              head       <= PW'(frame_ext);
              free_count <= free_count + PW'(1);
              state      <= ST_DONE;
            end
          end
        end
        ST_RD: begin
          state <= ST_POP;
        end
        ST_POP: begin
          if (slot_free) begin
            resp_valid         <= 1'b1;
            resp.granted_frame <= 8'(head);
            resp.status        <= STATUS_DONE;
            resp.last          <= (remaining == RW'(1));
            head               <= head_valid ? rd_data : PW'(FRAMES);
            free_count         <= free_count - PW'(1);
            remaining          <= remaining - RW'(1);
            state              <= (remaining == RW'(1)) ? ST_IDLE : ST_RD;
          end
        end
        ST_DONE, ST_REFUSE: begin
          if (slot_free) begin
            resp_valid         <= 1'b1;
            resp.granted_frame <= 8'd0;
            resp.status        <= (state == ST_REFUSE) ? STATUS_REFUSED : STATUS_DONE;
            resp.last          <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
